>>> rtl/quadratic_equation_solver_core_macros.svh
// Assertion macros shared by the checker of the quadratic equation solver core.
`ifndef QUADRATIC_EQUATION_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_EQUATION_SOLVER_CORE_MACROS_SVH

// Property checked on every rising edge of clk_i outside reset.
`define QES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define QES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/qes_pkg.sv
// Package of the quadratic equation solver: widths, codes and beat types.
`timescale 1ns / 1ps
package qes_pkg;

  localparam int COEFF_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CEPS_W      = 16;
  localparam int DEPS_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CNT_W       = 2;

  localparam int MAG_W    = COEFF_WIDTH;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int DISC_W   = PROD_W + 1;
  localparam int SQ_STEPS = (DISC_W + 1) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SREM_W   = ROOT_W + 3;
  localparam int NUM_W    = ROOT_W + 1;
  localparam int DEN_W    = MAG_W + 1;
  localparam int DVD_W    = NUM_W + FRAC_BITS;
  localparam int DREM_W   = DEN_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int LATENCY  = 4 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [CEPS_W-1:0] CEPS_RESET = CEPS_W'(1);
  localparam logic [DEPS_W-1:0] DEPS_RESET = DEPS_W'(429);

  localparam logic [CNT_W-1:0] CNT_NONE = CNT_W'(0);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_INF  = CNT_W'(3);

  typedef enum logic {
    CFG_COEFF_EPS = 1'b0,
    CFG_DISC_EPS  = 1'b1
  } qes_cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_QUAD,
    KIND_ONE,
    KIND_TWO
  } qes_kind_e;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] coeff_a;
    logic signed [COEFF_WIDTH-1:0] coeff_b;
    logic signed [COEFF_WIDTH-1:0] coeff_c;
  } qes_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]              root_count;
    logic signed [COEFF_WIDTH-1:0] root_first;
    logic signed [COEFF_WIDTH-1:0] root_second;
    logic                          saturated;
  } qes_out_t;

  // Signs, magnitudes and case of one coefficient set.
  typedef struct packed {
    qes_kind_e        kind;
    logic             na;
    logic             nb;
    logic             nc;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
  } qes_sq_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [SREM_W-1:0] rem;
  } qes_sq_lane_t;

  typedef struct packed {
    logic [DVD_W-1:0]  dvd;
    logic [DEN_W-1:0]  den;
    logic [DREM_W-1:0] rem;
    logic [DVD_W-1:0]  quo;
  } qes_dv_lane_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             neg1;
    logic             neg2;
  } qes_dv_side_t;

endpackage

>>> rtl/qes_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle.
`timescale 1ns / 1ps
module qes_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  qes_pkg::qes_sq_lane_t lane_i,
  input  qes_pkg::qes_sq_side_t side_i,
  output logic                  valid_o,
  output qes_pkg::qes_sq_lane_t lane_o,
  output qes_pkg::qes_sq_side_t side_o
);

  logic                  valid_q;
  qes_pkg::qes_sq_lane_t lane_d, lane_q;
  qes_pkg::qes_sq_side_t side_q;
  logic [qes_pkg::SREM_W-1:0] rem_sh;
  logic [qes_pkg::SREM_W-1:0] trial;

  always_comb begin
    rem_sh = {lane_i.rem[qes_pkg::SREM_W-3:0], lane_i.rad[qes_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, lane_i.root, 2'b01};
    lane_d.rad = {lane_i.rad[qes_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      lane_d.rem  = rem_sh - trial;
      lane_d.root = {lane_i.root[qes_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      lane_d.rem  = rem_sh;
      lane_d.root = {lane_i.root[qes_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;

endmodule

>>> rtl/qes_div_cell.sv
// One cell of the divider chain: one quotient bit per cycle for both roots.
`timescale 1ns / 1ps
module qes_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  qes_pkg::qes_dv_lane_t lane1_i,
  input  qes_pkg::qes_dv_lane_t lane2_i,
  input  qes_pkg::qes_dv_side_t side_i,
  output logic                  valid_o,
  output qes_pkg::qes_dv_lane_t lane1_o,
  output qes_pkg::qes_dv_lane_t lane2_o,
  output qes_pkg::qes_dv_side_t side_o
);

  logic                  valid_q;
  qes_pkg::qes_dv_lane_t lane1_q, lane2_q;
  qes_pkg::qes_dv_side_t side_q;

  // Restoring division step on one lane.
  function automatic qes_pkg::qes_dv_lane_t div_step(input qes_pkg::qes_dv_lane_t l);
    qes_pkg::qes_dv_lane_t      r;
    logic [qes_pkg::DREM_W-1:0] rem_sh;
    logic [qes_pkg::DREM_W-1:0] den_x;
    r      = l;
    rem_sh = {l.rem[qes_pkg::DREM_W-2:0], l.dvd[qes_pkg::DVD_W-1]};
    den_x  = {1'b0, l.den};
    r.dvd  = {l.dvd[qes_pkg::DVD_W-2:0], 1'b0};
    if (rem_sh >= den_x) begin
      r.rem = rem_sh - den_x;
      r.quo = {l.quo[qes_pkg::DVD_W-2:0], 1'b1};
    end else begin
      r.rem = rem_sh;
      r.quo = {l.quo[qes_pkg::DVD_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane1_q <= div_step(lane1_i);
    lane2_q <= div_step(lane2_i);
    side_q  <= side_i;
  end

  assign valid_o = valid_q;
  assign lane1_o = lane1_q;
  assign lane2_o = lane2_q;
  assign side_o  = side_q;

endmodule

>>> rtl/quadratic_equation_solver_core.sv
// Top level of the quadratic equation solver: front stages, square root and divider chains.
// A beat taken at one edge runs through stages 1 to 4, the 33-cell square root chain,
// the divider load register, the 50-cell divider chain and the output register to done_o.
// Throughput: one coefficient set per cycle, as busy_o stays low and no stage stalls.
// Reset clears the valid bits of every stage and loads both tolerances with their defaults.
`timescale 1ns / 1ps
module quadratic_equation_solver_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  qes_pkg::qes_in_t                     coeff_i,
  output logic                                 done_o,
  output qes_pkg::qes_out_t                    result_o,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_idx_i,
  input  logic [qes_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  // Configuration registers. Writes must arrive only while no beat is in flight; unchecked.
  logic [qes_pkg::CEPS_W-1:0] ceps_d, ceps_q;
  logic [qes_pkg::DEPS_W-1:0] deps_d, deps_q;

  always_comb begin
    ceps_d = ceps_q;
    deps_d = deps_q;
    if (cfg_we_i) begin
      unique case (qes_pkg::qes_cfg_idx_e'(cfg_idx_i))
        qes_pkg::CFG_COEFF_EPS: ceps_d = cfg_wdata_i[qes_pkg::CEPS_W-1:0];
        qes_pkg::CFG_DISC_EPS:  deps_d = cfg_wdata_i[qes_pkg::DEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceps_q <= qes_pkg::CEPS_RESET;
      deps_q <= qes_pkg::DEPS_RESET;
    end else begin
      ceps_q <= ceps_d;
      deps_q <= deps_d;
    end
  end

  // The pipeline never stalls, so every start beat is taken.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Stage 1: split each coefficient into sign and magnitude and classify the
  // degenerate cases. A zero tolerance still treats an exact zero as zero.
  logic                        s1_valid_q;
  qes_pkg::qes_sq_side_t       s1_side_d, s1_side_q;
  logic [qes_pkg::CEPS_W-1:0]  ceps_eff;
  logic                        za, zb, zc;

  always_comb begin
    ceps_eff     = (ceps_q == '0) ? qes_pkg::CEPS_W'(1) : ceps_q;
    s1_side_d.na = coeff_i.coeff_a[qes_pkg::COEFF_WIDTH-1];
    s1_side_d.nb = coeff_i.coeff_b[qes_pkg::COEFF_WIDTH-1];
    s1_side_d.nc = coeff_i.coeff_c[qes_pkg::COEFF_WIDTH-1];
    s1_side_d.ma = s1_side_d.na ? qes_pkg::MAG_W'(-coeff_i.coeff_a)
                                : qes_pkg::MAG_W'(coeff_i.coeff_a);
    s1_side_d.mb = s1_side_d.nb ? qes_pkg::MAG_W'(-coeff_i.coeff_b)
                                : qes_pkg::MAG_W'(coeff_i.coeff_b);
    s1_side_d.mc = s1_side_d.nc ? qes_pkg::MAG_W'(-coeff_i.coeff_c)
                                : qes_pkg::MAG_W'(coeff_i.coeff_c);
    za = s1_side_d.ma < qes_pkg::MAG_W'(ceps_eff);
    zb = s1_side_d.mb < qes_pkg::MAG_W'(ceps_eff);
    zc = s1_side_d.mc < qes_pkg::MAG_W'(ceps_eff);
    if (!za) begin
      s1_side_d.kind = qes_pkg::KIND_QUAD;
    end else if (!zb) begin
      s1_side_d.kind = qes_pkg::KIND_LIN;
    end else if (zc) begin
      s1_side_d.kind = qes_pkg::KIND_INF;
    end else begin
      s1_side_d.kind = qes_pkg::KIND_NONE;
    end
  end

  // Stage 2: the two exact products b*b and a*c.
  logic                        s2_valid_q;
  qes_pkg::qes_sq_side_t       s2_side_q;
  logic [qes_pkg::PROD_W-1:0]  bb_q, ac_q;

  // Stage 3: discriminant magnitude and sign. When a and c have opposite
  // signs the two terms add, otherwise the smaller is taken from the larger.
  logic                        s3_valid_q;
  qes_pkg::qes_sq_side_t       s3_side_q;
  logic [qes_pkg::DISC_W-1:0]  bbw, ac4, dmag_d, dmag_q;
  logic                        opposite, dneg_d, dneg_q;

  always_comb begin
    bbw      = {1'b0, bb_q};
    ac4      = {ac_q[qes_pkg::PROD_W-2:0], 2'b00};
    opposite = (s2_side_q.na != s2_side_q.nc) && (s2_side_q.ma != '0) && (s2_side_q.mc != '0);
    dneg_d   = !opposite && (bbw < ac4);
    if (opposite) begin
      dmag_d = bbw + ac4;
    end else if (dneg_d) begin
      dmag_d = ac4 - bbw;
    end else begin
      dmag_d = bbw - ac4;
    end
  end

  // Stage 4: compare against the tolerance to settle the root count of a
  // proper quadratic, then load the square root chain.
  logic                        sq_in_valid_q;
  qes_pkg::qes_sq_side_t       sq_in_side_d, sq_in_side_q;
  qes_pkg::qes_sq_lane_t       sq_in_lane_d, sq_in_lane_q;
  logic [qes_pkg::DISC_W-1:0]  deps_w;

  always_comb begin
    deps_w       = qes_pkg::DISC_W'(deps_q);
    sq_in_side_d = s3_side_q;
    if (s3_side_q.kind == qes_pkg::KIND_QUAD) begin
      if (dneg_q && (dmag_q > deps_w)) begin
        sq_in_side_d.kind = qes_pkg::KIND_NONE;
      end else if (dneg_q || (dmag_q < deps_w)) begin
        sq_in_side_d.kind = qes_pkg::KIND_ONE;
      end else begin
        sq_in_side_d.kind = qes_pkg::KIND_TWO;
      end
    end
    sq_in_lane_d.rad  = qes_pkg::RAD_W'(dmag_q);
    sq_in_lane_d.root = '0;
    sq_in_lane_d.rem  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      sq_in_valid_q <= 1'b0;
    end else begin
      s1_valid_q    <= accept;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      sq_in_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q    <= s1_side_d;
    s2_side_q    <= s1_side_q;
    bb_q         <= qes_pkg::PROD_W'(s1_side_q.mb * s1_side_q.mb);
    ac_q         <= qes_pkg::PROD_W'(s1_side_q.ma * s1_side_q.mc);
    s3_side_q    <= s2_side_q;
    dmag_q       <= dmag_d;
    dneg_q       <= dneg_d;
    sq_in_side_q <= sq_in_side_d;
    sq_in_lane_q <= sq_in_lane_d;
  end

  // Square root chain: each cell takes two radicand bits and yields one root bit.
  logic                  sq_valid [0:qes_pkg::SQ_STEPS];
  qes_pkg::qes_sq_lane_t sq_lane  [0:qes_pkg::SQ_STEPS];
  qes_pkg::qes_sq_side_t sq_side  [0:qes_pkg::SQ_STEPS];

  assign sq_valid[0] = sq_in_valid_q;
  assign sq_lane[0]  = sq_in_lane_q;
  assign sq_side[0]  = sq_in_side_q;

  for (genvar k = 0; k < qes_pkg::SQ_STEPS; k++) begin : g_sq
    qes_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .lane_i  (sq_lane[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_valid[k+1]),
      .lane_o  (sq_lane[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // Stage 5: form the numerators -b - s and -b + s, pick the dividend and
  // divisor of each root for the case at hand, and load the divider chain.
  qes_pkg::qes_sq_side_t       sq_out;
  logic [qes_pkg::NUM_W:0]     mbv, sroot, n1, n2;
  logic [qes_pkg::NUM_W-1:0]   m1, m2, nm1, nm2;
  logic [qes_pkg::DEN_W-1:0]   den2a, den1;
  logic                        sg1, sg2;
  logic                        dv_in_valid_q;
  qes_pkg::qes_dv_side_t       dv_in_side_d, dv_in_side_q;
  qes_pkg::qes_dv_lane_t       dv_in_l1_d, dv_in_l1_q, dv_in_l2_d, dv_in_l2_q;

  always_comb begin
    sq_out = sq_side[qes_pkg::SQ_STEPS];
    sroot  = (qes_pkg::NUM_W+1)'(sq_lane[qes_pkg::SQ_STEPS].root);
    mbv    = sq_out.nb ? (qes_pkg::NUM_W+1)'(sq_out.mb) : -((qes_pkg::NUM_W+1)'(sq_out.mb));
    n1     = mbv - sroot;
    n2     = mbv + sroot;
    sg1    = n1[qes_pkg::NUM_W];
    sg2    = n2[qes_pkg::NUM_W];
    m1     = sg1 ? qes_pkg::NUM_W'(-n1) : n1[qes_pkg::NUM_W-1:0];
    m2     = sg2 ? qes_pkg::NUM_W'(-n2) : n2[qes_pkg::NUM_W-1:0];
    den2a  = {sq_out.ma, 1'b0};

    nm1 = '0;
    nm2 = '0;
    den1 = den2a;
    dv_in_side_d.neg1  = 1'b0;
    dv_in_side_d.neg2  = 1'b0;
    dv_in_side_d.count = qes_pkg::CNT_NONE;
    case (sq_out.kind) inside
      qes_pkg::KIND_LIN: begin
        nm1  = qes_pkg::NUM_W'(sq_out.mc);
        den1 = qes_pkg::DEN_W'(sq_out.mb);
        dv_in_side_d.neg1  = (sq_out.nc == sq_out.nb) && (sq_out.mc != '0);
        dv_in_side_d.count = qes_pkg::CNT_ONE;
      end
      qes_pkg::KIND_ONE: begin
        nm1 = qes_pkg::NUM_W'(sq_out.mb);
        dv_in_side_d.neg1  = (sq_out.nb == sq_out.na) && (sq_out.mb != '0);
        dv_in_side_d.count = qes_pkg::CNT_ONE;
      end
      qes_pkg::KIND_TWO: begin
        nm1 = m1;
        nm2 = m2;
        dv_in_side_d.neg1  = (sg1 != sq_out.na) && (m1 != '0);
        dv_in_side_d.neg2  = (sg2 != sq_out.na) && (m2 != '0);
        dv_in_side_d.count = qes_pkg::CNT_TWO;
      end
      qes_pkg::KIND_INF: begin
        dv_in_side_d.count = qes_pkg::CNT_INF;
      end
      default: ;
    endcase

    dv_in_l1_d.dvd = {nm1, qes_pkg::FRAC_BITS'(0)};
    dv_in_l1_d.den = den1;
    dv_in_l1_d.rem = '0;
    dv_in_l1_d.quo = '0;
    dv_in_l2_d.dvd = {nm2, qes_pkg::FRAC_BITS'(0)};
    dv_in_l2_d.den = den2a;
    dv_in_l2_d.rem = '0;
    dv_in_l2_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_in_valid_q <= 1'b0;
    end else begin
      dv_in_valid_q <= sq_valid[qes_pkg::SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_in_side_q <= dv_in_side_d;
    dv_in_l1_q   <= dv_in_l1_d;
    dv_in_l2_q   <= dv_in_l2_d;
  end

  // Divider chain: both roots are divided side by side, one quotient bit a cell.
  logic                  dv_valid [0:qes_pkg::DIV_STEPS];
  qes_pkg::qes_dv_lane_t dv_l1    [0:qes_pkg::DIV_STEPS];
  qes_pkg::qes_dv_lane_t dv_l2    [0:qes_pkg::DIV_STEPS];
  qes_pkg::qes_dv_side_t dv_side  [0:qes_pkg::DIV_STEPS];

  assign dv_valid[0] = dv_in_valid_q;
  assign dv_l1[0]    = dv_in_l1_q;
  assign dv_l2[0]    = dv_in_l2_q;
  assign dv_side[0]  = dv_in_side_q;

  for (genvar k = 0; k < qes_pkg::DIV_STEPS; k++) begin : g_dv
    qes_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .lane1_i (dv_l1[k]),
      .lane2_i (dv_l2[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .lane1_o (dv_l1[k+1]),
      .lane2_o (dv_l2[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  // Output stage: clip each quotient to the signed range, apply the sign and
  // clear the roots that the count does not report.
  function automatic logic [qes_pkg::COEFF_WIDTH-1:0] clip_root(
    input  logic                      neg,
    input  logic [qes_pkg::DVD_W-1:0] quo,
    output logic                      sat
  );
    logic [qes_pkg::DVD_W-1:0]       lim;
    logic [qes_pkg::COEFF_WIDTH-1:0] m;
    lim = neg ? (qes_pkg::DVD_W'(1) << (qes_pkg::COEFF_WIDTH - 1))
              : (qes_pkg::DVD_W'(1) << (qes_pkg::COEFF_WIDTH - 1)) - qes_pkg::DVD_W'(1);
    sat = quo > lim;
    m   = sat ? lim[qes_pkg::COEFF_WIDTH-1:0] : quo[qes_pkg::COEFF_WIDTH-1:0];
    return neg ? -m : m;
  endfunction

  qes_pkg::qes_dv_side_t           fin_side;
  logic [qes_pkg::COEFF_WIDTH-1:0] r1, r2;
  logic                            sat1, sat2, use1, use2;
  qes_pkg::qes_out_t               out_d, out_q;
  logic                            done_q;

  always_comb begin
    fin_side = dv_side[qes_pkg::DIV_STEPS];
    r1   = clip_root(fin_side.neg1, dv_l1[qes_pkg::DIV_STEPS].quo, sat1);
    r2   = clip_root(fin_side.neg2, dv_l2[qes_pkg::DIV_STEPS].quo, sat2);
    use1 = (fin_side.count == qes_pkg::CNT_ONE) || (fin_side.count == qes_pkg::CNT_TWO);
    use2 = (fin_side.count == qes_pkg::CNT_TWO);
    out_d.root_count  = fin_side.count;
    out_d.root_first  = use1 ? r1 : '0;
    out_d.root_second = use2 ? r2 : '0;
    out_d.saturated   = (use1 & sat1) | (use2 & sat2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid[qes_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

>>> rtl/qes_checker.sv
// Port-level checker of the quadratic equation solver core, bound to the top level.
`timescale 1ns / 1ps
`include "quadratic_equation_solver_core_macros.svh"
module qes_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input qes_pkg::qes_in_t               coeff_i,
  input logic                           done_o,
  input qes_pkg::qes_out_t              result_o,
  input logic                           cfg_we_i,
  input logic [0:0]                     cfg_idx_i,
  input logic [qes_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int Lat = qes_pkg::LATENCY;

  `QES_ASSERT_NEVER(a_never_busy, busy_o, "busy raised although the pipeline never stalls")
  `QES_ASSERT(a_beat_done, (start_i && !busy_o) |-> ##Lat done_o, "accepted beat gave no result")
  `QES_ASSERT(a_done_beat, done_o |-> $past(start_i && !busy_o, Lat), "result without a beat")
  `QES_ASSERT(a_no_root_zero, (done_o && ((result_o.root_count == qes_pkg::CNT_NONE) || (result_o.root_count == qes_pkg::CNT_INF))) |-> ((result_o.root_first == '0) && (result_o.root_second == '0) && !result_o.saturated), "absent roots not cleared")
  `QES_ASSERT(a_one_root, (done_o && (result_o.root_count == qes_pkg::CNT_ONE)) |-> (result_o.root_second == '0), "second root set for a single root")

endmodule

bind quadratic_equation_solver_core qes_checker u_qes_checker (.*);
